// ===== hdl/abd_pkg.sv =====
// shared types and constants of the arcade bus decoder
`default_nettype none
package abd_pkg;

    typedef enum logic [2:0] {
        CMD_MEM_RD  = 3'd0,
        CMD_MEM_WR  = 3'd1,
        CMD_PORT_WR = 3'd2,
        CMD_PORT_RD = 3'd3,
        CMD_POLL    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ROM_NONE  = 2'd0,
        ROM_MAIN  = 2'd1,
        ROM_SOUND = 2'd2
    } t_rom_sel;

    localparam logic [0:0] CFG_DIP_ONE = 1'd0;
    localparam logic [0:0] CFG_DIP_TWO = 1'd1;

    localparam int RAM_DEPTH = 4352;
    localparam int RAM_AW    = 13;

    localparam logic [RAM_AW-1:0] TILE_BASE   = 13'h0800;
    localparam logic [RAM_AW-1:0] SPRITE_BASE = 13'h0c00;
    localparam logic [RAM_AW-1:0] SOUND_BASE  = 13'h0d00;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

endpackage
`default_nettype wire

// ===== hdl/abd_in_if.sv =====
// bus access channel into the decoder
`default_nettype none
interface abd_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic        cpu_select;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [6:0]  buttons;

    modport source (
        output valid, command, cpu_select, bus_address, write_data, buttons,
        input  ready
    );
    modport sink (
        input  valid, command, cpu_select, bus_address, write_data, buttons,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/abd_out_if.sv =====
// result channel out of the decoder
`default_nettype none
interface abd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [1:0]  rom_select;
    logic [13:0] rom_address;
    logic        sound_irq_fire;
    logic        nmi_fire;
    logic        custom_background;

    modport source (
        output valid, read_data, rom_select, rom_address, sound_irq_fire, nmi_fire,
               custom_background,
        input  ready
    );
    modport sink (
        input  valid, read_data, rom_select, rom_address, sound_irq_fire, nmi_fire,
               custom_background,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/abd_ram.sv =====
// shared ram with registered read and a zeroing sweep after reset
`default_nettype none
module abd_ram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  abd_pkg::t_ram_req   i_req,
    output logic [7:0]          o_rd_data,
    output logic                o_busy
);

    localparam logic [abd_pkg::RAM_AW-1:0] RAM_LAST = abd_pkg::RAM_AW'(abd_pkg::RAM_DEPTH - 1);

    logic [7:0]                  mem [abd_pkg::RAM_DEPTH];
    logic [7:0]                  r_rd_data;
    logic                        r_busy;
    logic [abd_pkg::RAM_AW-1:0]  r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_idx] <= 8'd0;
        end else if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            if (r_clr_idx == RAM_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

    a_clear_ends_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_clr_idx) == RAM_LAST)
        else $error("clear sweep ended before the last entry");

    a_no_access_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.we && !i_req.re)
        else $error("ram access during clear sweep");

    a_clear_stays_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> !r_busy)
        else $error("clear sweep restarted without reset");

endmodule
`default_nettype wire

// ===== hdl/arcade_bus_decoder_io.sv =====
// top level of the arcade bus decoder: memory map, ports, latches and interrupt flags
//
// One bus access is accepted per cycle unless the ram sweep or a stalled result holds it
// off; its result passes the stage and then the output register. The shared ram is
// addressed straight from the accepted beat, and its registered read data meets the stage
// register, where all decode and state updates happen. The output register decouples the
// sides, so a new access is taken while a result still waits. After reset a sweep zeroes
// the shared ram (4352 bytes) one byte per cycle while no access is accepted; dip switch
// writes are taken at any time. ROM reads return a fetch request instead of data.
`default_nettype none
module arcade_bus_decoder_io (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    abd_in_if.sink      i_req,
    abd_out_if.source   o_rsp
);

    localparam logic [15:0] MAIN_ROM_TOP = 16'h3fff;
    localparam logic [15:0] SND_ROM_TOP  = 16'h0fff;
    localparam logic [15:0] TILE_LO      = 16'h8800;
    localparam logic [15:0] TILE_HI      = 16'h8bff;
    localparam logic [15:0] ADDR_JOY     = 16'h9800;
    localparam logic [15:0] ADDR_DIP1    = 16'h9801;
    localparam logic [15:0] ADDR_DIP2    = 16'h9802;
    localparam logic [15:0] ADDR_IN3     = 16'h9803;
    localparam logic [15:0] ADDR_LATCH   = 16'ha000;
    localparam logic [15:0] ADDR_IRQ     = 16'ha001;
    localparam logic [15:0] ADDR_CTRL_HI = 16'ha003;
    localparam logic [15:0] ADDR_NMI     = 16'ha801;
    localparam logic [15:0] ADDR_BG      = 16'ha803;
    localparam logic [15:0] ADDR_WDOG    = 16'hb000;
    localparam logic [7:0]  PORT_SEL_A   = 8'h10;
    localparam logic [7:0]  PORT_SEL_B   = 8'h40;
    localparam logic [7:0]  PORT_CHIP_HI = 8'h20;
    localparam logic [7:0]  PORT_CHIP_LO = 8'h80;
    localparam logic [3:0]  SEL_LATCH    = 4'd14;

    // configuration
    logic [7:0] r_dip_one;
    logic [7:0] r_dip_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_one <= 8'd0;
            r_dip_two <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                abd_pkg::CFG_DIP_ONE: r_dip_one <= i_cfg_data;
                abd_pkg::CFG_DIP_TWO: r_dip_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic r_s1_vld;
    logic r_out_vld;
    logic ram_busy;
    logic s1_adv;
    logic in_acc;

    assign s1_adv      = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !ram_busy && (!r_s1_vld || s1_adv);
    assign in_acc      = i_req.valid && i_req.ready;

    // ram addressing from the accepted beat
    abd_pkg::t_ram_req ram_req;
    logic [7:0]        ram_rd;
    logic              hit_rw;
    logic              hit_spr;
    logic [15:0]       a_in;

    assign a_in = i_req.bus_address;

    always_comb begin
        hit_rw      = 1'b0;
        hit_spr     = 1'b0;
        ram_req     = '0;
        if (!i_req.cpu_select) begin
            if (a_in[15:11] == 5'b10000) begin
                hit_rw       = 1'b1;
                ram_req.addr = {2'b00, a_in[10:0]};
            end else if (a_in inside {[TILE_LO:TILE_HI]}) begin
                hit_rw       = 1'b1;
                ram_req.addr = abd_pkg::TILE_BASE + {3'b000, a_in[9:0]};
            end else if (a_in[15:8] == 8'h90) begin
                hit_spr      = 1'b1;
                ram_req.addr = abd_pkg::SPRITE_BASE + {5'b00000, a_in[7:0]};
            end
        end else if (a_in[15:12] == 4'h8) begin
            // sound ram repeats every 1K across its window
            hit_rw       = 1'b1;
            ram_req.addr = abd_pkg::SOUND_BASE + {3'b000, a_in[9:0]};
        end
        ram_req.wdata = i_req.write_data;
        ram_req.we    = in_acc && (i_req.command == abd_pkg::CMD_MEM_WR) && (hit_rw || hit_spr);
        ram_req.re    = in_acc && (i_req.command == abd_pkg::CMD_MEM_RD) && hit_rw;
    end

    abd_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (ram_rd),
        .o_busy    (ram_busy)
    );

    // stage register
    abd_pkg::t_cmd r_cmd;
    logic          r_cpu;
    logic [15:0]   r_addr;
    logic [7:0]    r_wdata;
    logic [6:0]    r_btn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
        if (in_acc) begin
            r_cmd   <= abd_pkg::t_cmd'(i_req.command);
            r_cpu   <= i_req.cpu_select;
            r_addr  <= i_req.bus_address;
            r_wdata <= i_req.write_data;
            r_btn   <= i_req.buttons;
        end
    end

    // decoder state
    logic [7:0] r_chip [32];
    logic [3:0] r_chip_sel;
    logic [7:0] r_latch;
    logic       r_irq_pend;
    logic       r_nmi_en;
    logic       r_skip_nmi;
    logic       r_lockout;
    logic       r_bg;

    logic [3:0] n_chip_sel;
    logic [7:0] n_latch;
    logic       n_irq_pend;
    logic       n_nmi_en;
    logic       n_skip_nmi;
    logic       n_lockout;
    logic       n_bg;
    logic       chip_we;
    logic [4:0] chip_idx;
    logic [7:0] chip_rd;
    logic [7:0] port_num;
    logic [7:0] joy;
    logic       lock_next;
    logic [7:0] remap;

    logic [7:0]  n_rd;
    logic [1:0]  n_rsel;
    logic [13:0] n_raddr;
    logic        n_irqf;
    logic        n_nmif;

    assign port_num     = r_addr[7:0];
    assign chip_idx     = {port_num == PORT_CHIP_HI, r_chip_sel};
    assign chip_rd      = r_chip[chip_idx];

    // fire reads pressed only once it has been seen released since reset
    assign lock_next = r_lockout && r_btn[5];
    assign joy = {1'b1, ~r_btn[0], ~r_btn[1], ~r_btn[2], ~r_btn[3], ~r_btn[4], 1'b1,
                  ~(!lock_next && r_btn[5])};

    always_comb begin
        case (r_wdata)
            8'd3:    remap = 8'd6;
            8'd5:    remap = 8'd7;
            8'd10:   remap = 8'd11;
            default: remap = r_wdata;
        endcase
    end

    always_comb begin
        n_rd       = 8'd0;
        n_rsel     = abd_pkg::ROM_NONE;
        n_raddr    = 14'd0;
        n_irqf     = 1'b0;
        n_nmif     = 1'b0;
        n_chip_sel = r_chip_sel;
        n_latch    = r_latch;
        n_irq_pend = r_irq_pend;
        n_nmi_en   = r_nmi_en;
        n_skip_nmi = r_skip_nmi;
        n_lockout  = r_lockout;
        n_bg       = r_bg;
        chip_we    = 1'b0;
        case (r_cmd)
            abd_pkg::CMD_MEM_RD: begin
                if (!r_cpu) begin
                    if (r_addr <= MAIN_ROM_TOP) begin
                        n_rsel  = abd_pkg::ROM_MAIN;
                        n_raddr = r_addr[13:0];
                    end else if (r_addr[15:11] == 5'b10000) begin
                        n_rd = ram_rd;
                    end else if (r_addr inside {[TILE_LO:TILE_HI]}) begin
                        n_rd = ram_rd;
                    end else if (r_addr == ADDR_JOY) begin
                        n_rd      = joy;
                        n_lockout = lock_next;
                    end else if (r_addr == ADDR_DIP1) begin
                        n_rd = r_dip_one;
                    end else if (r_addr == ADDR_DIP2) begin
                        n_rd = r_dip_two + {7'd0, ~r_btn[6]};
                    end else if (r_addr == ADDR_IN3) begin
                        n_rd = 8'hff;
                    end else if (r_addr inside {[ADDR_LATCH:ADDR_CTRL_HI]}) begin
                        n_rd = 8'd0;
                    end else if (r_addr == ADDR_WDOG) begin
                        n_rd = 8'd0;
                    end else begin
                        n_rd = 8'hff;
                    end
                end else begin
                    if (r_addr <= SND_ROM_TOP) begin
                        n_rsel  = abd_pkg::ROM_SOUND;
                        n_raddr = {2'b00, r_addr[11:0]};
                    end else if (r_addr[15:12] == 4'h8) begin
                        n_rd = ram_rd;
                    end else begin
                        n_rd = 8'hff;
                    end
                end
            end
            abd_pkg::CMD_MEM_WR: begin
                // ram writes already went out with the accepted beat
                if (!r_cpu) begin
                    if (r_addr == ADDR_LATCH) begin
                        n_latch = remap;
                    end else if (r_addr == ADDR_IRQ) begin
                        n_irq_pend = r_wdata[3];
                    end else if (r_addr == ADDR_NMI) begin
                        // the first enable is swallowed
                        if (r_wdata[0] && r_skip_nmi) begin
                            n_nmi_en   = 1'b0;
                            n_skip_nmi = 1'b0;
                        end else begin
                            n_nmi_en = r_wdata[0];
                        end
                    end else if (r_addr == ADDR_BG) begin
                        n_bg = r_wdata[0];
                    end
                end
            end
            abd_pkg::CMD_PORT_WR: begin
                if (r_cpu) begin
                    if (port_num == PORT_SEL_A || port_num == PORT_SEL_B) begin
                        n_chip_sel = r_wdata[3:0];
                    end else if (port_num == PORT_CHIP_HI || port_num == PORT_CHIP_LO) begin
                        chip_we = 1'b1;
                    end
                end
            end
            abd_pkg::CMD_PORT_RD: begin
                if (r_cpu) begin
                    if (port_num == PORT_CHIP_HI && r_chip_sel < SEL_LATCH) begin
                        n_rd = chip_rd;
                    end else if (port_num == PORT_CHIP_LO) begin
                        if (r_chip_sel < SEL_LATCH) begin
                            n_rd = chip_rd;
                        end else if (r_chip_sel == SEL_LATCH) begin
                            n_rd = r_latch;
                        end
                    end
                end
            end
            abd_pkg::CMD_POLL: begin
                n_irqf     = r_irq_pend;
                n_irq_pend = 1'b0;
                n_nmif     = r_nmi_en;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                r_chip[i] <= 8'd0;
            end
            r_chip_sel <= 4'd0;
            r_latch    <= 8'd0;
            r_irq_pend <= 1'b0;
            r_nmi_en   <= 1'b0;
            r_skip_nmi <= 1'b1;
            r_lockout  <= 1'b1;
            r_bg       <= 1'b0;
        end else if (s1_adv) begin
            if (chip_we) begin
                r_chip[chip_idx] <= r_wdata;
            end
            r_chip_sel <= n_chip_sel;
            r_latch    <= n_latch;
            r_irq_pend <= n_irq_pend;
            r_nmi_en   <= n_nmi_en;
            r_skip_nmi <= n_skip_nmi;
            r_lockout  <= n_lockout;
            r_bg       <= n_bg;
        end
    end

    // output register
    logic [7:0]  r_rd;
    logic [1:0]  r_rsel;
    logic [13:0] r_raddr;
    logic        r_irqf;
    logic        r_nmif;
    logic        r_bg_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (s1_adv) begin
            r_rd     <= n_rd;
            r_rsel   <= n_rsel;
            r_raddr  <= n_raddr;
            r_irqf   <= n_irqf;
            r_nmif   <= n_nmif;
            r_bg_out <= n_bg;
        end
    end

    assign o_rsp.valid             = r_out_vld;
    assign o_rsp.read_data         = r_rd;
    assign o_rsp.rom_select        = r_rsel;
    assign o_rsp.rom_address       = r_raddr;
    assign o_rsp.sound_irq_fire    = r_irqf;
    assign o_rsp.nmi_fire          = r_nmif;
    assign o_rsp.custom_background = r_bg_out;

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_busy |-> !i_req.ready)
        else $error("access accepted during ram clear");

    a_rom_fetch_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.rom_select != abd_pkg::ROM_NONE) |-> o_rsp.read_data == 8'd0)
        else $error("rom fetch beat carries read data");

    a_nmi_after_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nmi_en |-> !r_skip_nmi)
        else $error("nmi enabled before first enable was skipped");

    a_poll_clears_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_cmd == abd_pkg::CMD_POLL) |=> !r_irq_pend)
        else $error("audio irq still pending after poll");

endmodule
`default_nettype wire

// ===== sim/arcade_bus_decoder_io_tb.sv =====
// testbench of the arcade bus decoder: directed and random accesses against a decode model
module arcade_bus_decoder_io_tb;

    localparam logic       CPU_MAIN        = 1'b0;
    localparam logic       CPU_SOUND       = 1'b1;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam logic [15:0] ADDR_JOYSTICK   = 16'h9800;
    localparam logic [15:0] ADDR_DIP_ONE    = 16'h9801;
    localparam logic [15:0] ADDR_DIP_TWO    = 16'h9802;
    localparam logic [15:0] ADDR_PORT_THREE = 16'h9803;
    localparam logic [15:0] ADDR_SOUND_CMD  = 16'ha000;
    localparam logic [15:0] ADDR_IRQ_ARM    = 16'ha001;
    localparam logic [15:0] ADDR_NMI_ENABLE = 16'ha801;
    localparam logic [15:0] ADDR_BACKGROUND = 16'ha803;
    localparam logic [15:0] ADDR_STUB_ZERO  = 16'hb000;

    localparam logic [7:0] PORT_SELECT_A  = 8'h10;
    localparam logic [7:0] PORT_SELECT_B  = 8'h40;
    localparam logic [7:0] PORT_CHIP_HIGH = 8'h20;
    localparam logic [7:0] PORT_CHIP_LOW  = 8'h80;
    localparam logic [3:0] SELECT_LATCH   = 4'd14;

    localparam int IDLE_PERCENT    = 26;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_CYCLES = 200000;
    localparam int PRINT_LIMIT     = 40;

    typedef struct packed {
        logic [2:0]  command;
        logic        cpu;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [6:0]  buttons;
    } t_access;

    typedef struct packed {
        logic [7:0]        read_data;
        abd_pkg::t_rom_sel rom_select;
        logic [13:0]       rom_address;
        logic              irq_fire;
        logic              nmi_fire;
        logic              background;
    } t_reply;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    abd_in_if  access_bus ();
    abd_out_if reply_bus ();

    arcade_bus_decoder_io DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (access_bus),
        .o_rsp      (reply_bus)
    );

    // decode model state
    logic [7:0] ram_image [abd_pkg::RAM_DEPTH];
    logic [7:0] chip_regs [32];
    logic [3:0] chip_select;
    logic [7:0] sound_cmd;
    logic [7:0] filter_byte;
    logic [7:0] dip_one;
    logic [7:0] dip_two;
    logic       irq_pending;
    logic       nmi_on;
    logic       nmi_skip;
    logic       fire_locked;
    logic       background_on;

    t_reply      awaited_replies [$];
    int unsigned error_count = 0;
    bit          calm = 1'b0;
    int          hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(WATCHDOG_CYCLES * 10);
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic reset_model();
        foreach (ram_image[i]) ram_image[i] = 8'h00;
        foreach (chip_regs[i]) chip_regs[i] = 8'h00;
        chip_select   = 4'd0;
        sound_cmd     = 8'h00;
        filter_byte   = 8'h00;
        dip_one       = 8'h00;
        dip_two       = 8'h00;
        irq_pending   = 1'b0;
        nmi_on        = 1'b0;
        nmi_skip      = 1'b1;
        fire_locked   = 1'b1;
        background_on = 1'b0;
    endtask

    // serves one access against the model state and returns the reply it produces
    function automatic t_reply decode_access(input t_access a);
        t_reply     r;
        logic [7:0] v;
        logic [7:0] port;
        r = '0;
        r.rom_select = abd_pkg::ROM_NONE;
        port = a.addr[7:0];
        case (a.command)
            abd_pkg::CMD_MEM_RD: begin
                if (a.cpu == CPU_SOUND) begin
                    if (a.addr < 16'h1000) begin
                        r.rom_select  = abd_pkg::ROM_SOUND;
                        r.rom_address = a.addr[13:0];
                    end else if (a.addr[15:12] == 4'h8) begin
                        r.read_data = ram_image[abd_pkg::SOUND_BASE + a.addr[9:0]];
                    end else begin
                        r.read_data = 8'hff;
                    end
                end else if (a.addr <= 16'h3fff) begin
                    r.rom_select  = abd_pkg::ROM_MAIN;
                    r.rom_address = a.addr[13:0];
                end else if (a.addr[15:11] == 5'b10000) begin
                    r.read_data = ram_image[a.addr[10:0]];
                end else if (a.addr >= 16'h8800 && a.addr <= 16'h8bff) begin
                    r.read_data = ram_image[abd_pkg::TILE_BASE + a.addr[9:0]];
                end else if (a.addr == ADDR_JOYSTICK) begin
                    v = 8'hff;
                    v[6] = ~a.buttons[0];
                    v[5] = ~a.buttons[1];
                    v[4] = ~a.buttons[2];
                    v[3] = ~a.buttons[3];
                    v[2] = ~a.buttons[4];
                    // fire stays hidden until it has been seen released once
                    if (fire_locked && !a.buttons[5]) fire_locked = 1'b0;
                    if (!fire_locked && a.buttons[5]) v[0] = 1'b0;
                    r.read_data = v;
                end else if (a.addr == ADDR_DIP_ONE) begin
                    r.read_data = dip_one;
                end else if (a.addr == ADDR_DIP_TWO) begin
                    r.read_data = dip_two + (a.buttons[6] ? 8'd0 : 8'd1);
                end else if (a.addr == ADDR_PORT_THREE) begin
                    r.read_data = 8'hff;
                end else if (a.addr >= ADDR_SOUND_CMD && a.addr <= ADDR_SOUND_CMD + 16'd3) begin
                    r.read_data = 8'h00;
                end else if (a.addr == ADDR_STUB_ZERO) begin
                    r.read_data = 8'h00;
                end else begin
                    r.read_data = 8'hff;
                end
            end
            abd_pkg::CMD_MEM_WR: begin
                if (a.cpu == CPU_SOUND) begin
                    if (a.addr[15:12] == 4'h8)
                        ram_image[abd_pkg::SOUND_BASE + a.addr[9:0]] = a.data;
                    else if (a.addr[15:12] == 4'h9) filter_byte = a.data;
                end else if (a.addr[15:11] == 5'b10000) begin
                    ram_image[a.addr[10:0]] = a.data;
                end else if (a.addr >= 16'h8800 && a.addr <= 16'h8bff) begin
                    ram_image[abd_pkg::TILE_BASE + a.addr[9:0]] = a.data;
                end else if (a.addr >= 16'h9000 && a.addr <= 16'h90ff) begin
                    ram_image[abd_pkg::SPRITE_BASE + a.addr[7:0]] = a.data;
                end else if (a.addr == ADDR_SOUND_CMD) begin
                    case (a.data)
                        8'd3:    sound_cmd = 8'd6;
                        8'd5:    sound_cmd = 8'd7;
                        8'd10:   sound_cmd = 8'd11;
                        default: sound_cmd = a.data;
                    endcase
                end else if (a.addr == ADDR_IRQ_ARM) begin
                    irq_pending = a.data[3];
                end else if (a.addr == ADDR_NMI_ENABLE) begin
                    nmi_on = a.data[0];
                    if (nmi_on && nmi_skip) begin
                        nmi_on   = 1'b0;
                        nmi_skip = 1'b0;
                    end
                end else if (a.addr == ADDR_BACKGROUND) begin
                    background_on = a.data[0];
                end
            end
            abd_pkg::CMD_PORT_WR: begin
                if (a.cpu == CPU_SOUND) begin
                    if (port == PORT_SELECT_A || port == PORT_SELECT_B)
                        chip_select = a.data[3:0];
                    else if (port == PORT_CHIP_HIGH)
                        chip_regs[{1'b1, chip_select}] = a.data;
                    else if (port == PORT_CHIP_LOW)
                        chip_regs[{1'b0, chip_select}] = a.data;
                end
            end
            abd_pkg::CMD_PORT_RD: begin
                if (a.cpu == CPU_SOUND) begin
                    if (port == PORT_CHIP_HIGH && chip_select < SELECT_LATCH)
                        r.read_data = chip_regs[{1'b1, chip_select}];
                    else if (port == PORT_CHIP_LOW && chip_select < SELECT_LATCH)
                        r.read_data = chip_regs[{1'b0, chip_select}];
                    else if (port == PORT_CHIP_LOW && chip_select == SELECT_LATCH)
                        r.read_data = sound_cmd;
                end
            end
            abd_pkg::CMD_POLL: begin
                r.irq_fire  = irq_pending;
                irq_pending = 1'b0;
                r.nmi_fire  = nmi_on;
            end
            default: ;
        endcase
        r.background = background_on;
        return r;
    endfunction

    function automatic t_access access_of(input logic [2:0] command, input logic cpu,
                                          input logic [15:0] addr, input logic [7:0] data,
                                          input logic [6:0] buttons);
        t_access a;
        a.command = command;
        a.cpu     = cpu;
        a.addr    = addr;
        a.data    = data;
        a.buttons = buttons;
        return a;
    endfunction

    // small offsets half the time so reads land on bytes written before
    function automatic int unsigned near_offset(input int unsigned span);
        return $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, span);
    endfunction

    function automatic t_access random_access();
        t_access     a;
        int unsigned pick;
        a.command = $urandom_range(0, 1) ? abd_pkg::CMD_MEM_WR : abd_pkg::CMD_MEM_RD;
        a.cpu     = CPU_MAIN;
        a.addr    = 16'($urandom);
        a.data    = 8'($urandom);
        a.buttons = 7'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // noise, spare commands included
            a.command = 3'($urandom);
            a.cpu     = 1'($urandom);
        end else if (pick < 30) begin
            case ($urandom_range(0, 2))
                0:       a.addr = 16'h8000 + 16'(near_offset(32'h07ff));
                1:       a.addr = 16'h8800 + 16'(near_offset(32'h03ff));
                default: a.addr = 16'h9000 + 16'(near_offset(32'h00ff));
            endcase
        end else if (pick < 36) begin
            a.command = abd_pkg::CMD_MEM_RD;
            a.addr    = 16'($urandom_range(0, 16'h3fff));
        end else if (pick < 56) begin
            case ($urandom_range(0, 11))
                0, 1: a.addr = ADDR_JOYSTICK;
                2:    a.addr = ADDR_DIP_ONE;
                3:    a.addr = ADDR_DIP_TWO;
                4:    a.addr = ADDR_PORT_THREE;
                5: begin
                    a.addr = ADDR_SOUND_CMD;
                    if ($urandom_range(0, 1)) a.data = 8'($urandom_range(0, 15));
                end
                6:       a.addr = ADDR_SOUND_CMD + 16'($urandom_range(1, 3));
                7:       a.addr = ADDR_IRQ_ARM;
                8:       a.addr = ADDR_STUB_ZERO;
                9:       a.addr = ADDR_NMI_ENABLE;
                10:      a.addr = ADDR_BACKGROUND;
                default: a.addr = 16'($urandom_range(16'h4000, 16'hffff));
            endcase
        end else if (pick < 70) begin
            a.cpu = CPU_SOUND;
            case ($urandom_range(0, 3))
                0: a.addr = 16'($urandom_range(0, 16'h0fff));
                1, 2: a.addr = 16'h8000 + 16'($urandom_range(0, 3) * 1024)
                             + 16'(near_offset(32'd1023));
                default: a.addr = 16'h9000 + 16'(near_offset(32'h0fff));
            endcase
        end else if (pick < 92) begin
            a.cpu     = $urandom_range(0, 9) ? CPU_SOUND : CPU_MAIN;
            a.command = $urandom_range(0, 1) ? abd_pkg::CMD_PORT_WR : abd_pkg::CMD_PORT_RD;
            case ($urandom_range(0, 4))
                0:       a.addr[7:0] = PORT_SELECT_A;
                1:       a.addr[7:0] = PORT_SELECT_B;
                2:       a.addr[7:0] = PORT_CHIP_HIGH;
                3:       a.addr[7:0] = PORT_CHIP_LOW;
                default: ;
            endcase
        end else begin
            a.command = abd_pkg::CMD_POLL;
            a.cpu     = 1'($urandom);
        end
        return a;
    endfunction

    task automatic send_access(input t_access a);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) @(negedge i_clk);
        access_bus.command     <= a.command;
        access_bus.cpu_select  <= a.cpu;
        access_bus.bus_address <= a.addr;
        access_bus.write_data  <= a.data;
        access_bus.buttons     <= a.buttons;
        access_bus.valid       <= 1'b1;
        @(posedge i_clk);
        while (!access_bus.ready) @(posedge i_clk);
        awaited_replies.push_back(decode_access(a));
        access_bus.valid <= 1'b0;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        while (awaited_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (awaited_replies.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));
            awaited_replies.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dips(input logic [7:0] one, input logic [7:0] two);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= abd_pkg::CFG_DIP_ONE;
        i_cfg_data <= one;
        @(negedge i_clk);
        i_cfg_idx  <= abd_pkg::CFG_DIP_TWO;
        i_cfg_data <= two;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        dip_one = one;
        dip_two = two;
    endtask

    task automatic test_memory_map();
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_MAIN, 16'h0000, 8'h00, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_MAIN, 16'h3fff, 8'h00, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_WR, CPU_MAIN, 16'h87ff, 8'hff, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_MAIN, 16'h87ff, 8'h00, 7'h00));
        // sprite ram takes writes but reads back as open bus
        send_access(access_of(abd_pkg::CMD_MEM_WR, CPU_MAIN, 16'h90ff, 8'ha5, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_MAIN, 16'h90ff, 8'h00, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_SOUND, 16'h0fff, 8'h00, 7'h00));
        // top of the sound window reads back through the lowest mirror
        send_access(access_of(abd_pkg::CMD_MEM_WR, CPU_SOUND, 16'h8fff, 8'h3c, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_SOUND, 16'h83ff, 8'h00, 7'h00));
    endtask

    task automatic test_player_inputs();
        drain_results();
        write_dips(8'hff, 8'hff);
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_MAIN, ADDR_JOYSTICK, 8'h00, 7'h7f));
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_MAIN, ADDR_JOYSTICK, 8'h00, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_MAIN, ADDR_JOYSTICK, 8'h00, 7'h20));
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_MAIN, ADDR_DIP_TWO, 8'h00, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_RD, CPU_MAIN, ADDR_DIP_TWO, 8'h00, 7'h40));
    endtask

    task automatic test_sound_latch();
        send_access(access_of(abd_pkg::CMD_MEM_WR, CPU_MAIN, ADDR_SOUND_CMD, 8'd3, 7'h00));
        send_access(access_of(abd_pkg::CMD_PORT_WR, CPU_SOUND, {8'h00, PORT_SELECT_B}, 8'hfe,
                              7'h00));
        send_access(access_of(abd_pkg::CMD_PORT_RD, CPU_SOUND, {8'h00, PORT_CHIP_LOW}, 8'h00,
                              7'h00));
    endtask

    task automatic test_interrupt_flags();
        send_access(access_of(abd_pkg::CMD_MEM_WR, CPU_MAIN, ADDR_IRQ_ARM, 8'h08, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_WR, CPU_MAIN, ADDR_NMI_ENABLE, 8'h01, 7'h00));
        send_access(access_of(abd_pkg::CMD_POLL, CPU_SOUND, 16'hffff, 8'hff, 7'h7f));
        send_access(access_of(abd_pkg::CMD_MEM_WR, CPU_MAIN, ADDR_NMI_ENABLE, 8'h01, 7'h00));
        send_access(access_of(abd_pkg::CMD_POLL, CPU_MAIN, 16'h0000, 8'h00, 7'h00));
        send_access(access_of(abd_pkg::CMD_MEM_WR, CPU_MAIN, ADDR_BACKGROUND, 8'h01, 7'h00));
    endtask

    task automatic test_sound_chip_ports();
        send_access(access_of(abd_pkg::CMD_PORT_WR, CPU_SOUND, {8'hff, PORT_SELECT_A}, 8'h03,
                              7'h00));
        send_access(access_of(abd_pkg::CMD_PORT_WR, CPU_SOUND, {8'h00, PORT_CHIP_HIGH}, 8'h99,
                              7'h00));
        send_access(access_of(abd_pkg::CMD_PORT_RD, CPU_SOUND, {8'h00, PORT_CHIP_HIGH}, 8'h00,
                              7'h00));
        send_access(access_of(abd_pkg::CMD_PORT_RD, CPU_MAIN, {8'h00, PORT_CHIP_HIGH}, 8'h00,
                              7'h00));
        send_access(access_of(abd_pkg::CMD_PORT_WR, CPU_SOUND, {8'h00, PORT_SELECT_A}, 8'hff,
                              7'h00));
        send_access(access_of(abd_pkg::CMD_PORT_RD, CPU_SOUND, {8'h00, PORT_CHIP_LOW}, 8'h00,
                              7'h00));
    endtask

    task automatic test_spare_commands();
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_access(access_of(3'(c), 1'($urandom), 16'($urandom), 8'($urandom),
                                  7'($urandom)));
    endtask

    task automatic test_random_traffic(input int count, input logic [7:0] one,
                                       input logic [7:0] two, input bit steady);
        drain_results();
        write_dips(one, two);
        calm = steady;
        repeat (count) send_access(random_access());
        calm = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits it out
    task automatic test_backpressure();
        drain_results();
        calm = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        repeat (40) send_access(random_access());
        calm = 1'b0;
        drain_results();
    endtask

    initial begin : reply_side
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                reply_bus.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                reply_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && reply_bus.valid && reply_bus.ready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("result beat with no access waiting");
            end else begin
                want = awaited_replies.pop_front();
                compare_field("read_data", 16'(reply_bus.read_data), 16'(want.read_data));
                compare_field("rom_select", 16'(reply_bus.rom_select),
                              16'(want.rom_select));
                compare_field("rom_address", 16'(reply_bus.rom_address),
                              16'(want.rom_address));
                compare_field("sound_irq_fire", 16'(reply_bus.sound_irq_fire),
                              16'(want.irq_fire));
                compare_field("nmi_fire", 16'(reply_bus.nmi_fire), 16'(want.nmi_fire));
                compare_field("custom_background", 16'(reply_bus.custom_background),
                              16'(want.background));
            end
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = abd_pkg::CFG_DIP_ONE;
        i_cfg_data             = 8'h00;
        access_bus.valid       = 1'b0;
        access_bus.command     = abd_pkg::CMD_MEM_RD;
        access_bus.cpu_select  = CPU_MAIN;
        access_bus.bus_address = 16'h0000;
        access_bus.write_data  = 8'h00;
        access_bus.buttons     = 7'h00;
        reply_bus.ready        = 1'b0;
        reset_model();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_memory_map();
        test_player_inputs();
        test_sound_latch();
        test_interrupt_flags();
        test_sound_chip_ports();
        test_spare_commands();
        test_random_traffic(300, 8'h00, 8'h00, 1'b0);
        test_random_traffic(300, 8'hff, 8'hff, 1'b0);
        test_random_traffic(350, 8'($urandom), 8'($urandom), 1'b1);
        test_backpressure();
        test_random_traffic(300, 8'($urandom), 8'($urandom), 1'b0);
        test_random_traffic(400, 8'h80, 8'h7f, 1'b0);
        drain_results();

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
